@@ sv/sha1sh_pkg.sv @@
package sha1sh_pkg;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_ABSORB  = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [4:0][31:0] INIT_HASH = {H4, H3, H2, H1, H0};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [6:0] ROUND_K1      = 7'd20;
  localparam logic [6:0] ROUND_K2      = 7'd40;
  localparam logic [6:0] ROUND_K3      = 7'd60;
  localparam logic [5:0] FULL_FILL     = 6'd63;
  localparam logic [5:0] LEN_FILL      = 6'd56;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ZERO,
    S_LEN,
    S_COMP,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  typedef struct packed {
    logic       restart;
    logic       shift;
    src_t       src;
    logic       load;
    logic       round_en;
    logic [6:0] round;
    logic       fold;
    logic [2:0] word;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

endpackage

@@ sv/sha1sh_dp.sv @@
module sha1sh_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  sha1sh_pkg::ctrl_cmd_t  cmd,
  input  logic [7:0]             data_byte,
  output sha1sh_pkg::dp_stat_t   stat,
  output logic [31:0]            digest_word
);
  import sha1sh_pkg::*;

  logic [4:0][31:0] chain;
  logic [4:0][31:0] regs;
  logic [511:0]     win;
  logic [5:0]       fill;
  logic [63:0]      len;

  logic [7:0]  byte_in;
  logic [31:0] w0;
  logic [31:0] mix;
  logic [31:0] new_w;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic [63:0] len_sum;

  always_comb begin
    case (cmd.src)
      SRC_DATA: byte_in = data_byte;
      SRC_PAD:  byte_in = PAD_BYTE;
      SRC_ZERO: byte_in = 8'd0;
      SRC_LEN:  byte_in = len[63:56];
      default:  byte_in = 8'd0;
    endcase
  end

  assign w0    = win[511:480];
  assign mix   = w0 ^ win[447:416] ^ win[255:224] ^ win[95:64];
  assign new_w = {mix[30:0], mix[31]};

  always_comb begin
    if (cmd.round < ROUND_K1) begin
      f = (regs[1] & regs[2]) | (~regs[1] & regs[3]);
      k = K0;
    end else if (cmd.round < ROUND_K2) begin
      f = regs[1] ^ regs[2] ^ regs[3];
      k = K1;
    end else if (cmd.round < ROUND_K3) begin
      f = (regs[1] & regs[2]) | (regs[1] & regs[3]) | (regs[2] & regs[3]);
      k = K2;
    end else begin
      f = regs[1] ^ regs[2] ^ regs[3];
      k = K3;
    end
  end

  assign tmp     = {regs[0][26:0], regs[0][31:27]} + f + regs[4] + w0 + k;
  assign len_sum = len + 64'd8;

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      chain <= INIT_HASH;
      fill  <= '0;
      len   <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= chain[i] + regs[i];
        end
      end
      if (cmd.shift) begin
        fill <= fill + 6'd1;
        if (cmd.src == SRC_DATA) begin
          len <= (&len[63:3]) ? '1 : len_sum;
        end else if (cmd.src == SRC_LEN) begin
          len <= {len[55:0], 8'd0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win <= {win[503:0], byte_in};
    end else if (cmd.round_en) begin
      win <= {win[479:0], new_w};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      regs <= chain;
    end else if (cmd.round_en) begin
      regs[4] <= regs[3];
      regs[3] <= regs[2];
      regs[2] <= {regs[1][1:0], regs[1][31:2]};
      regs[1] <= regs[0];
      regs[0] <= tmp;
    end
  end

  always_comb begin
    case (cmd.word)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      3'd4:    digest_word = chain[4];
      default: digest_word = chain[0];
    endcase
  end

  assign stat.fill = fill;

endmodule

@@ sv/sha1sh_ctrl.sv @@
module sha1sh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             word_number,
  output logic                   last_word,
  input  sha1sh_pkg::dp_stat_t   stat,
  output sha1sh_pkg::ctrl_cmd_t  cmd
);
  import sha1sh_pkg::*;

  state_t     state;
  state_t     state_next;
  state_t     ret;
  state_t     ret_next;
  logic [6:0] round;
  logic [6:0] round_next;
  logic [2:0] word;
  logic [2:0] word_next;
  logic       full;

  assign full = (stat.fill == FULL_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      round <= '0;
      word  <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      round <= round_next;
      word  <= word_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    round_next = round;
    word_next  = word;
    cmd        = '0;
    cmd.round  = round;
    cmd.word   = word;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (command)
            CMD_RESTART: cmd.restart = 1'b1;
            CMD_ABSORB: begin
              cmd.shift = 1'b1;
              cmd.src   = SRC_DATA;
              if (full) begin
                cmd.load   = 1'b1;
                round_next = '0;
                ret_next   = S_IDLE;
                state_next = S_COMP;
              end
            end
            CMD_FINISH: state_next = S_PAD;
            default: ;
          endcase
        end
      end
      S_PAD: begin
        cmd.shift  = 1'b1;
        cmd.src    = SRC_PAD;
        state_next = S_ZERO;
        if (full) begin
          cmd.load   = 1'b1;
          round_next = '0;
          ret_next   = S_ZERO;
          state_next = S_COMP;
        end
      end
      S_ZERO: begin
        if (stat.fill == LEN_FILL) begin
          state_next = S_LEN;
        end else begin
          cmd.shift = 1'b1;
          cmd.src   = SRC_ZERO;
          if (full) begin
            cmd.load   = 1'b1;
            round_next = '0;
            ret_next   = S_ZERO;
            state_next = S_COMP;
          end
        end
      end
      S_LEN: begin
        cmd.shift = 1'b1;
        cmd.src   = SRC_LEN;
        if (full) begin
          cmd.load   = 1'b1;
          round_next = '0;
          ret_next   = S_EMIT;
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        if (round == LAST_ROUND) begin
          round_next = '0;
          state_next = S_FOLD;
        end else begin
          round_next = round + 7'd1;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        word_next  = '0;
        state_next = ret;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (word == LAST_WORD_IDX) begin
            cmd.restart = 1'b1;
            word_next   = '0;
            state_next  = S_IDLE;
          end else begin
            word_next = word + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign word_number = word;
  assign last_word   = (word == LAST_WORD_IDX);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    round <= LAST_ROUND)
    else $error("round counter out of range");

  a_comp_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && round == LAST_ROUND) |=> (state == S_FOLD))
    else $error("compression did not end after the last round");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (state == S_IDLE && word == 3'd0))
    else $error("no return to idle after the last digest word");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    word <= LAST_WORD_IDX)
    else $error("digest word index out of range");

endmodule

@@ sv/sha1_stream_hasher.sv @@
// Streaming SHA-1 hasher.
// Input channel (in_valid/in_ready): command and data_byte. Command 0 restarts
// the hash, 1 absorbs data_byte, 2 pads the message and returns the digest;
// command 3 is taken and dropped.
// Output channel (out_valid/out_ready): digest_word, word_number, last_word;
// five items per finish, word 0 first, last_word set on word 4.
// Every 64th absorbed byte starts a compression on the single round unit,
// which runs the rounds one at a time and then folds the result into the
// chain.
// A finish shifts the padding and length into the block one byte a cycle
// between compressions, with an idle step before the length, runs one or two
// compressions, then presents the five digest words, one a cycle while
// out_ready is high.
// No input is taken from a finish until the last digest word has gone.
// While the receiver stalls, the current word is held unchanged.
// Reset (rst, synchronous) loads the standard initial hash and clears the
// byte count and bit length; the bit length saturates at all ones.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);
  import sha1sh_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sha1sh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .word_number (word_number),
    .last_word   (last_word),
    .stat        (stat),
    .cmd         (cmd)
  );

  sha1sh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .stat        (stat),
    .digest_word (digest_word)
  );

endmodule
